### rtl/cfgu_pkg.sv
package cfgu_pkg;

  localparam int unsigned TapDepth   = 1024;
  localparam int unsigned UnitDepth  = 1024;
  localparam int unsigned StoreDepth = 8192;
  localparam int unsigned DataW      = 32;
  localparam int unsigned MaxBatch   = 8;

  typedef enum logic [2:0] {
    MODE_LD_TAP  = 3'd0,
    MODE_LD_BIAS = 3'd1,
    MODE_LD_ERR  = 3'd2,
    MODE_LD_ACT  = 3'd3,
    MODE_RUN     = 3'd4,
    MODE_RD_TAP  = 3'd5,
    MODE_RD_BIAS = 3'd6,
    MODE_NONE    = 3'd7
  } mode_e;

  typedef enum logic [3:0] {
    CFG_IMAGE_WIDTH   = 4'd0,
    CFG_IMAGE_HEIGHT  = 4'd1,
    CFG_IN_CHANNELS   = 4'd2,
    CFG_OUT_CHANNELS  = 4'd3,
    CFG_KERNEL_WIDTH  = 4'd4,
    CFG_KERNEL_HEIGHT = 4'd5,
    CFG_STEP_SIZE     = 4'd6,
    CFG_BATCH_SIZE    = 4'd7
  } cfg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_GRID,
    ST_POS,
    ST_PAIR,
    ST_RD,
    ST_MUL1,
    ST_SAT1,
    ST_MUL2,
    ST_SAT2,
    ST_DIVI,
    ST_DIV,
    ST_WB,
    ST_ADV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [2:0]         mode;
    logic [12:0]        slot;
    logic signed [31:0] datum;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [9:0]         slot_out;
    logic signed [31:0] result_value;
  } out_item_t;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic signed [63:0] sh;
    if (p[63]) begin
      sh = (p + 64'sd65535) >>> 16;
    end else begin
      sh = p >>> 16;
    end
    return sat32({sh[63], sh});
  endfunction

endpackage

### rtl/conv_filter_gradient_update.sv
// Convolution filter gradient update, Q16.16.
// Command channel: start_i with in_i (mode, slot, datum) is taken when busy_o
// is low. Loads of taps, biases, errors and activations never raise busy_o;
// reads of a tap or bias do not either, and return their result on valid_o/out_o
// in the cycle after the transaction.
// A run transaction raises busy_o while it walks every output position and
// every tap pairing with in-range addresses; a pairing reads, multiplies and
// saturates twice for each batch sample, then divides the sum by the batch
// size in the bit-serial divider and writes back; each output position does
// the same for its bias, one multiply per sample. Setup counts the grid size.
// The run ends with one valid_o pulse of kind 1; busy_o is still high during
// the pulse and falls after it. valid_o is a one-cycle strobe; the receiver
// cannot stall it. Configuration: cfg_valid_i/cfg_index_i/cfg_data_i,
// cfg_ready_o always high; write only while idle. Reset restores register
// defaults and leaves the stores undefined until written.
module conv_filter_gradient_update (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  cfgu_pkg::in_item_t in_i,
  output logic               valid_o,
  output cfgu_pkg::out_item_t out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  cfgu_pkg::state_e state_q, state_d;

  logic [6:0] cw_q, ch_q;
  logic [4:0] cci_q, cco_q, ckw_q, ckh_q, cs_q;
  logic [3:0] cb_q;

  logic signed [31:0] lr_q, lr_d;
  logic [4:0]  s_q, s_d;
  logic [3:0]  nb_q, nb_d;
  logic [6:0]  remw_q, remw_d, remh_q, remh_d, gw_q, gw_d, gh_q, gh_d;
  logic [9:0]  kk_q, kk_d;
  logic [13:0] plane_q, plane_d;
  logic [11:0] sw_q, sw_d;
  logic [14:0] tstride_q, tstride_d;
  logic [4:0]  co_q, co_d, ci_q, ci_d, ky_q, ky_d, kx_q, kx_d;
  logic [6:0]  yi_q, yi_d, xi_q, xi_d;
  logic [3:0]  d_q, d_d;
  logic [10:0] o_q, o_d;
  logic [20:0] t_q, t_d, tbase_q, tbase_d;
  logic [19:0] i_q, i_d, row_q, row_d, chan_q, chan_d;
  logic [14:0] xbase_q, xbase_d, ybase_q, ybase_d;
  logic        bias_q, bias_d;
  logic signed [63:0] p_q, p_d, acc_q, acc_d;
  logic signed [31:0] le_q, le_d;
  logic [63:0] quo_q, quo_d;
  logic [3:0]  rem_q, rem_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        rd_pend_q, rd_ok_q, rd_bias_q;
  logic [9:0]  slot_q;

  logic        accept;
  logic [2:0]  mode;
  logic        tap_we, bias_we;
  logic [9:0]  tap_raddr, bias_raddr;
  logic [31:0] tap_rdata, bias_rdata, err_rdata, act_rdata;
  logic signed [31:0] wb_val;
  logic [4:0]  s_eff;
  logic [4:0]  r2;
  logic        ge;
  logic        last_d;
  logic signed [31:0] old_v;
  logic signed [63:0] q_s;

  assign accept      = start_i && !busy_o;
  assign mode        = in_i.mode;
  assign busy_o      = (state_q != cfgu_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign s_eff       = (cs_q == 5'd0) ? 5'd1 : cs_q;
  assign last_d      = ((d_q + 4'd1) == nb_q);
  assign r2          = {rem_q, quo_q[63]};
  assign ge          = (r2 >= {1'b0, nb_q});
  assign old_v       = bias_q ? $signed(bias_rdata) : $signed(tap_rdata);
  assign q_s         = neg_q ? -$signed(quo_q) : $signed(quo_q);
  assign wb_val      = cfgu_pkg::sat32({old_v[31], {32{old_v[31]}}, old_v}
                                       - {q_s[63], q_s});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cw_q  <= 7'd32;
      ch_q  <= 7'd32;
      cci_q <= 5'd1;
      cco_q <= 5'd1;
      ckw_q <= 5'd3;
      ckh_q <= 5'd3;
      cs_q  <= 5'd1;
      cb_q  <= 4'd1;
    end else if (cfg_valid_i) begin
      case (cfgu_pkg::cfg_index_e'(cfg_index_i))
        cfgu_pkg::CFG_IMAGE_WIDTH:   cw_q  <= cfg_data_i[6:0];
        cfgu_pkg::CFG_IMAGE_HEIGHT:  ch_q  <= cfg_data_i[6:0];
        cfgu_pkg::CFG_IN_CHANNELS:   cci_q <= cfg_data_i[4:0];
        cfgu_pkg::CFG_OUT_CHANNELS:  cco_q <= cfg_data_i[4:0];
        cfgu_pkg::CFG_KERNEL_WIDTH:  ckw_q <= cfg_data_i[4:0];
        cfgu_pkg::CFG_KERNEL_HEIGHT: ckh_q <= cfg_data_i[4:0];
        cfgu_pkg::CFG_STEP_SIZE:     cs_q  <= cfg_data_i[4:0];
        cfgu_pkg::CFG_BATCH_SIZE:    cb_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cfgu_pkg::ST_IDLE: begin
        if (accept && mode == cfgu_pkg::MODE_RUN) begin
          state_d = cfgu_pkg::ST_SETUP;
        end
      end
      cfgu_pkg::ST_SETUP: state_d = cfgu_pkg::ST_GRID;
      cfgu_pkg::ST_GRID: begin
        if (remw_q < s_q && remh_q < s_q) begin
          if (cco_q == 5'd0 || gw_q == 7'd0 || gh_q == 7'd0) begin
            state_d = cfgu_pkg::ST_DONE;
          end else begin
            state_d = cfgu_pkg::ST_POS;
          end
        end
      end
      cfgu_pkg::ST_POS: begin
        if (o_q[10]) begin
          state_d = cfgu_pkg::ST_DONE;
        end else if (cci_q == 5'd0 || ckh_q == 5'd0 || ckw_q == 5'd0) begin
          state_d = cfgu_pkg::ST_RD;
        end else begin
          state_d = cfgu_pkg::ST_PAIR;
        end
      end
      cfgu_pkg::ST_PAIR: begin
        if (i_q[19:10] == 10'd0 && t_q[20:10] == 11'd0) begin
          state_d = cfgu_pkg::ST_RD;
        end else begin
          state_d = cfgu_pkg::ST_ADV;
        end
      end
      cfgu_pkg::ST_RD:   state_d = cfgu_pkg::ST_MUL1;
      cfgu_pkg::ST_MUL1: state_d = cfgu_pkg::ST_SAT1;
      cfgu_pkg::ST_SAT1: begin
        if (!bias_q) begin
          state_d = cfgu_pkg::ST_MUL2;
        end else if (last_d) begin
          state_d = cfgu_pkg::ST_DIVI;
        end else begin
          state_d = cfgu_pkg::ST_RD;
        end
      end
      cfgu_pkg::ST_MUL2: state_d = cfgu_pkg::ST_SAT2;
      cfgu_pkg::ST_SAT2: state_d = last_d ? cfgu_pkg::ST_DIVI : cfgu_pkg::ST_RD;
      cfgu_pkg::ST_DIVI: state_d = cfgu_pkg::ST_DIV;
      cfgu_pkg::ST_DIV:  state_d = (cnt_q == 6'd63) ? cfgu_pkg::ST_WB : cfgu_pkg::ST_DIV;
      cfgu_pkg::ST_WB: begin
        if (!bias_q) begin
          state_d = cfgu_pkg::ST_ADV;
        end else if (xi_q + 7'd1 == gw_q && yi_q + 7'd1 == gh_q && co_q + 5'd1 == cco_q) begin
          state_d = cfgu_pkg::ST_DONE;
        end else begin
          state_d = cfgu_pkg::ST_POS;
        end
      end
      cfgu_pkg::ST_ADV: begin
        if (kx_q + 5'd1 == ckw_q && ky_q + 5'd1 == ckh_q && ci_q + 5'd1 == cci_q) begin
          state_d = cfgu_pkg::ST_RD;
        end else begin
          state_d = cfgu_pkg::ST_PAIR;
        end
      end
      cfgu_pkg::ST_DONE: state_d = cfgu_pkg::ST_IDLE;
      default: state_d = cfgu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    lr_d = lr_q; s_d = s_q; nb_d = nb_q; remw_d = remw_q; remh_d = remh_q;
    gw_d = gw_q; gh_d = gh_q; kk_d = kk_q; plane_d = plane_q; sw_d = sw_q;
    tstride_d = tstride_q; co_d = co_q; ci_d = ci_q; ky_d = ky_q; kx_d = kx_q;
    yi_d = yi_q; xi_d = xi_q; d_d = d_q; o_d = o_q; t_d = t_q; tbase_d = tbase_q;
    i_d = i_q; row_d = row_q; chan_d = chan_q; xbase_d = xbase_q; ybase_d = ybase_q;
    bias_d = bias_q; p_d = p_q; acc_d = acc_q; le_d = le_q; quo_d = quo_q;
    rem_d = rem_q; neg_d = neg_q; cnt_d = cnt_q;
    tap_we = 1'b0;
    bias_we = 1'b0;
    case (state_q)
      cfgu_pkg::ST_IDLE: begin
        lr_d = in_i.datum;
      end
      cfgu_pkg::ST_SETUP: begin
        s_d     = s_eff;
        nb_d    = (cb_q == 4'd0) ? 4'd1 : ((cb_q > 4'(cfgu_pkg::MaxBatch))
                  ? 4'(cfgu_pkg::MaxBatch) : cb_q);
        remw_d  = (cw_q > {2'b0, ckw_q}) ? cw_q - {2'b0, ckw_q} : 7'd0;
        remh_d  = (ch_q > {2'b0, ckh_q}) ? ch_q - {2'b0, ckh_q} : 7'd0;
        gw_d    = 7'd0;
        gh_d    = 7'd0;
        kk_d    = ckw_q * ckh_q;
        plane_d = cw_q * ch_q;
        sw_d    = s_eff * cw_q;
      end
      cfgu_pkg::ST_GRID: begin
        tstride_d = cci_q * kk_q;
        if (remw_q >= {2'b0, s_q}) begin
          remw_d = remw_q - {2'b0, s_q};
          gw_d   = gw_q + 7'd1;
        end
        if (remh_q >= {2'b0, s_q}) begin
          remh_d = remh_q - {2'b0, s_q};
          gh_d   = gh_q + 7'd1;
        end
        co_d = 5'd0; yi_d = 7'd0; xi_d = 7'd0; o_d = 11'd0;
        tbase_d = 21'd0; xbase_d = 15'd0; ybase_d = 15'd0;
      end
      cfgu_pkg::ST_POS: begin
        i_d = {5'b0, xbase_q}; row_d = {5'b0, xbase_q}; chan_d = {5'b0, xbase_q};
        t_d = tbase_q; ci_d = 5'd0; ky_d = 5'd0; kx_d = 5'd0;
        acc_d = 64'sd0; d_d = 4'd0;
        bias_d = (cci_q == 5'd0 || ckh_q == 5'd0 || ckw_q == 5'd0);
      end
      cfgu_pkg::ST_PAIR: begin
        acc_d = 64'sd0;
        d_d   = 4'd0;
      end
      cfgu_pkg::ST_MUL1: begin
        p_d = lr_q * $signed(err_rdata);
      end
      cfgu_pkg::ST_SAT1: begin
        le_d = cfgu_pkg::qscale(p_q);
        if (bias_q) begin
          acc_d = acc_q + 64'(cfgu_pkg::qscale(p_q));
          d_d   = d_q + 4'd1;
        end
      end
      cfgu_pkg::ST_MUL2: begin
        p_d = le_q * $signed(act_rdata);
      end
      cfgu_pkg::ST_SAT2: begin
        acc_d = acc_q + 64'(cfgu_pkg::qscale(p_q));
        d_d   = d_q + 4'd1;
      end
      cfgu_pkg::ST_DIVI: begin
        neg_d = acc_q[63];
        quo_d = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
        rem_d = 4'd0;
        cnt_d = 6'd0;
      end
      cfgu_pkg::ST_DIV: begin
        rem_d = ge ? 4'(r2 - {1'b0, nb_q}) : r2[3:0];
        quo_d = {quo_q[62:0], ge};
        cnt_d = cnt_q + 6'd1;
      end
      cfgu_pkg::ST_WB: begin
        tap_we  = !bias_q;
        bias_we = bias_q;
        if (bias_q) begin
          o_d = o_q + 11'd1;
          if (xi_q + 7'd1 == gw_q) begin
            xi_d = 7'd0;
            if (yi_q + 7'd1 == gh_q) begin
              yi_d = 7'd0;
              co_d = co_q + 5'd1;
              tbase_d = tbase_q + {6'b0, tstride_q};
              ybase_d = 15'd0;
              xbase_d = 15'd0;
            end else begin
              yi_d = yi_q + 7'd1;
              ybase_d = ybase_q + {3'b0, sw_q};
              xbase_d = ybase_q + {3'b0, sw_q};
            end
          end else begin
            xi_d = xi_q + 7'd1;
            xbase_d = xbase_q + {10'b0, s_q};
          end
        end
      end
      cfgu_pkg::ST_ADV: begin
        t_d = t_q + 21'd1;
        d_d = 4'd0;
        acc_d = 64'sd0;
        if (kx_q + 5'd1 == ckw_q) begin
          kx_d = 5'd0;
          if (ky_q + 5'd1 == ckh_q) begin
            ky_d = 5'd0;
            if (ci_q + 5'd1 == cci_q) begin
              bias_d = 1'b1;
            end else begin
              ci_d = ci_q + 5'd1;
              chan_d = chan_q + {6'b0, plane_q};
              row_d  = chan_q + {6'b0, plane_q};
              i_d    = chan_q + {6'b0, plane_q};
            end
          end else begin
            ky_d = ky_q + 5'd1;
            row_d = row_q + {13'b0, cw_q};
            i_d   = row_q + {13'b0, cw_q};
          end
        end else begin
          kx_d = kx_q + 5'd1;
          i_d  = i_q + 20'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cfgu_pkg::ST_IDLE;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= accept && (mode == cfgu_pkg::MODE_RD_TAP
                              || mode == cfgu_pkg::MODE_RD_BIAS);
    end
  end

  always_ff @(posedge clk_i) begin
    lr_q <= lr_d; s_q <= s_d; nb_q <= nb_d; remw_q <= remw_d; remh_q <= remh_d;
    gw_q <= gw_d; gh_q <= gh_d; kk_q <= kk_d; plane_q <= plane_d; sw_q <= sw_d;
    tstride_q <= tstride_d; co_q <= co_d; ci_q <= ci_d; ky_q <= ky_d; kx_q <= kx_d;
    yi_q <= yi_d; xi_q <= xi_d; d_q <= d_d; o_q <= o_d; t_q <= t_d;
    tbase_q <= tbase_d; i_q <= i_d; row_q <= row_d; chan_q <= chan_d;
    xbase_q <= xbase_d; ybase_q <= ybase_d; bias_q <= bias_d; p_q <= p_d;
    acc_q <= acc_d; le_q <= le_d; quo_q <= quo_d; rem_q <= rem_d; neg_q <= neg_d;
    cnt_q <= cnt_d;
    rd_ok_q   <= (in_i.slot[12:10] == 3'd0);
    rd_bias_q <= (mode == cfgu_pkg::MODE_RD_BIAS);
    slot_q    <= in_i.slot[9:0];
  end

  assign tap_raddr  = busy_o ? t_q[9:0] : in_i.slot[9:0];
  assign bias_raddr = busy_o ? o_q[9:0] : in_i.slot[9:0];

  cfgu_ram #(.Width(32), .Depth(cfgu_pkg::TapDepth)) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_we || (accept && mode == cfgu_pkg::MODE_LD_TAP
                         && in_i.slot[12:10] == 3'd0)),
    .waddr_i (busy_o ? t_q[9:0] : in_i.slot[9:0]),
    .wdata_i (busy_o ? wb_val : in_i.datum),
    .raddr_i (tap_raddr),
    .rdata_o (tap_rdata)
  );

  cfgu_ram #(.Width(32), .Depth(cfgu_pkg::UnitDepth)) u_bias_ram (
    .clk_i   (clk_i),
    .we_i    (bias_we || (accept && mode == cfgu_pkg::MODE_LD_BIAS
                          && in_i.slot[12:10] == 3'd0)),
    .waddr_i (busy_o ? o_q[9:0] : in_i.slot[9:0]),
    .wdata_i (busy_o ? wb_val : in_i.datum),
    .raddr_i (bias_raddr),
    .rdata_o (bias_rdata)
  );

  cfgu_ram #(.Width(32), .Depth(cfgu_pkg::StoreDepth)) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (accept && mode == cfgu_pkg::MODE_LD_ERR),
    .waddr_i (in_i.slot),
    .wdata_i (in_i.datum),
    .raddr_i ({o_q[9:0], d_q[2:0]}),
    .rdata_o (err_rdata)
  );

  cfgu_ram #(.Width(32), .Depth(cfgu_pkg::StoreDepth)) u_act_ram (
    .clk_i   (clk_i),
    .we_i    (accept && mode == cfgu_pkg::MODE_LD_ACT),
    .waddr_i (in_i.slot),
    .wdata_i (in_i.datum),
    .raddr_i ({i_q[9:0], d_q[2:0]}),
    .rdata_o (act_rdata)
  );

  always_comb begin
    valid_o = rd_pend_q || (state_q == cfgu_pkg::ST_DONE);
    out_o.kind = (state_q == cfgu_pkg::ST_DONE);
    out_o.slot_out = rd_pend_q ? slot_q : 10'd0;
    out_o.result_value = 32'sd0;
    if (rd_pend_q && rd_ok_q) begin
      out_o.result_value = rd_bias_q ? $signed(bias_rdata) : $signed(tap_rdata);
    end
  end

endmodule

### rtl/cfgu_ram.sv
module cfgu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
